@@ src/lmu_pkg.sv @@
// Shared constants for the logit-domain multiplier update pipeline.
`default_nettype none
package lmu_pkg;

   // Fixed-point format of the multiplier
   localparam int FRAC_BITS = 16;
   localparam int PW        = FRAC_BITS + 1;      // prior incl. the value one
   localparam logic [PW-1:0] ONE_VAL = PW'(1) << FRAC_BITS;
   localparam int DIV_BITS  = 61 - FRAC_BITS;
   localparam int M_SHIFT   = DIV_BITS - 30;

   // Datapath widths
   localparam int RES_W  = 25;                    // residual, signed Q8
   localparam int T_W    = 55;                    // residual times coefficient
   localparam int K_W    = 14;                    // integer part of the exponent
   localparam int Q30_W  = 31;                    // series terms and sum
   localparam int A_W    = PW + Q30_W;            // prior times 2^f
   localparam int ND_W   = 63;                    // numerator and denominator
   localparam int Q_W    = FRAC_BITS + 2;         // quotient incl. rounding bit
   localparam int TERMS  = 14;

   // 0.05*log2(e) in Q32 and ln2 in Q30
   localparam logic signed [29:0] COEF_Q32 = 30'sd309816401;
   localparam logic [29:0]        LN2_Q30  = 30'd744261118;
   localparam logic [Q30_W-1:0]   ONE_Q30  = Q30_W'(1) << 30;

   // floor(2^30 / n) for the series divisions
   localparam logic [30:0] RECIP_Q30 [1:TERMS] = '{
      31'd1073741824, 31'd536870912, 31'd357913941, 31'd268435456,
      31'd214748364,  31'd178956970, 31'd153391689, 31'd134217728,
      31'd119304647,  31'd107374182, 31'd97612893,  31'd89478485,
      31'd82595524,   31'd76695844
   };

   // Register map
   localparam logic [1:0] CSR_FLOOR   = 2'd0;
   localparam logic [1:0] CSR_CEILING = 2'd1;
   localparam logic [15:0] FLOOR_RESET   = 16'd3277;
   localparam logic [15:0] CEILING_RESET = 16'd62259;

endpackage
`default_nettype wire

@@ src/logit_domain_multiplier_update_core.sv @@
// Pipelined logit-domain multiplier update: p' = p*e^d / (1 - p + p*e^d).
//
// Usage
//   A request (prior, realized, predicted) is taken on every clock edge at
//   which start is high and busy is low. busy is always low: the pipeline
//   takes one request per cycle, back to back, with no gaps needed.
//   The result appears on rsp_updated_value / rsp_hit_bound with rsp_valid
//   high for exactly one cycle. Results leave in request order; throughput
//   is one result per cycle. Most of the pipeline depth is the exponent
//   series (14 terms, three stages each: multiply, reciprocal multiply,
//   correction) and the 18-stage restoring divider for the final sigmoid
//   quotient. The receiver cannot stall: results are simply presented and
//   dropped. The user must write floor/ceiling through the csr_ port only
//   while idle; the block does not enforce it. Synchronous reset clears
//   all pipeline valid bits and loads the default floor (3277) and ceiling
//   (62259); requests in flight are discarded.
`default_nettype none
module logit_domain_multiplier_update_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_prior_value,
   input  wire logic signed [23:0] req_realized_bps,
   input  wire logic signed [23:0] req_predicted_bps,
   output logic             rsp_valid,
   output logic [15:0]      rsp_updated_value,
   output logic             rsp_hit_bound,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int PW    = lmu_pkg::PW;
   localparam int K_W   = lmu_pkg::K_W;
   localparam int Q_W   = lmu_pkg::Q_W;
   localparam int ND_W  = lmu_pkg::ND_W;
   localparam int A_W   = lmu_pkg::A_W;
   localparam int SW    = lmu_pkg::Q30_W;
   localparam int TERMS = lmu_pkg::TERMS;

   assign busy = 1'b0;

   // Configuration registers
   logic [15:0] floor_level_ff, ceiling_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_level_ff   <= lmu_pkg::FLOOR_RESET;
         ceiling_level_ff <= lmu_pkg::CEILING_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lmu_pkg::CSR_FLOOR:   floor_level_ff   <= csr_wdata;
            lmu_pkg::CSR_CEILING: ceiling_level_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 0: clamp the prior, form the residual
   logic signed [17:0] lo_in, hi_in, pp_in;
   logic [PW-1:0]      p_in;
   logic signed [lmu_pkg::RES_W-1:0] resid_in;
   logic               s0_valid_ff;
   logic [PW-1:0]      s0_p_ff;
   logic signed [lmu_pkg::RES_W-1:0] s0_resid_ff;

   always_comb begin
      lo_in = signed'({2'b00, floor_level_ff}) + 18'sd1;
      hi_in = signed'({2'b00, ceiling_level_ff}) - 18'sd1;
      pp_in = signed'({2'b00, req_prior_value});
      if (pp_in > hi_in) pp_in = hi_in;
      if (pp_in < lo_in) pp_in = lo_in;
      p_in = PW'(pp_in);
      if (p_in > lmu_pkg::ONE_VAL) p_in = lmu_pkg::ONE_VAL;
      resid_in = lmu_pkg::RES_W'(req_realized_bps) - lmu_pkg::RES_W'(req_predicted_bps);
   end

   always_ff @(posedge clock) begin
      s0_valid_ff <= start & ~busy & ~reset;
      s0_p_ff     <= p_in;
      s0_resid_ff <= resid_in;
   end

   // Stage 1: exponent in base two, split into integer and fraction
   logic signed [lmu_pkg::T_W-1:0] t_in;
   logic                 s1_valid_ff;
   logic [PW-1:0]        s1_p_ff;
   logic signed [K_W-1:0] s1_k_ff;
   logic [29:0]          s1_fhi_ff;

   assign t_in = lmu_pkg::T_W'(s0_resid_ff) * lmu_pkg::T_W'(lmu_pkg::COEF_Q32);

   always_ff @(posedge clock) begin
      s1_valid_ff <= s0_valid_ff & ~reset;
      s1_p_ff     <= s0_p_ff;
      s1_k_ff     <= t_in[53:40];
      s1_fhi_ff   <= t_in[39:10];
   end

   // Series pipeline state; index 0 holds y and the first term
   logic                  ser_valid_ff [0:TERMS];
   logic [PW-1:0]         ser_p_ff     [0:TERMS];
   logic signed [K_W-1:0] ser_k_ff     [0:TERMS];
   logic [29:0]           ser_y_ff     [0:TERMS];
   logic [SW-1:0]         ser_term_ff  [0:TERMS];
   logic [SW-1:0]         ser_sum_ff   [0:TERMS];

   // Stage 2: y = f * ln2
   logic [59:0] y_prod_in;
   assign y_prod_in = 60'(s1_fhi_ff) * 60'(lmu_pkg::LN2_Q30);

   always_ff @(posedge clock) begin
      ser_valid_ff[0] <= s1_valid_ff & ~reset;
      ser_p_ff[0]     <= s1_p_ff;
      ser_k_ff[0]     <= s1_k_ff;
      ser_y_ff[0]     <= y_prod_in[59:30];
      ser_term_ff[0]  <= lmu_pkg::ONE_Q30;
      ser_sum_ff[0]   <= lmu_pkg::ONE_Q30;
   end

   // Per-term intermediate stages
   logic                  ma_valid_ff [1:TERMS];
   logic [PW-1:0]         ma_p_ff     [1:TERMS];
   logic signed [K_W-1:0] ma_k_ff     [1:TERMS];
   logic [29:0]           ma_y_ff     [1:TERMS];
   logic [SW-1:0]         ma_x_ff     [1:TERMS];
   logic [SW-1:0]         ma_sum_ff   [1:TERMS];
   logic                  mb_valid_ff [1:TERMS];
   logic [PW-1:0]         mb_p_ff     [1:TERMS];
   logic signed [K_W-1:0] mb_k_ff     [1:TERMS];
   logic [29:0]           mb_y_ff     [1:TERMS];
   logic [SW-1:0]         mb_x_ff     [1:TERMS];
   logic [SW-1:0]         mb_est_ff   [1:TERMS];
   logic [SW-1:0]         mb_sum_ff   [1:TERMS];

   for (genvar n = 1; n <= TERMS; n++) begin : g_term
      logic [60:0]   tprod_in;
      logic [61:0]   eprod_in;
      logic [34:0]   chk_in, rem_in;
      logic [SW-1:0] term_in;

      // term times y
      assign tprod_in = 61'(ser_term_ff[n-1]) * 61'(ser_y_ff[n-1]);

      always_ff @(posedge clock) begin
         ma_valid_ff[n] <= ser_valid_ff[n-1] & ~reset;
         ma_p_ff[n]     <= ser_p_ff[n-1];
         ma_k_ff[n]     <= ser_k_ff[n-1];
         ma_y_ff[n]     <= ser_y_ff[n-1];
         ma_x_ff[n]     <= tprod_in[60:30];
         ma_sum_ff[n]   <= ser_sum_ff[n-1];
      end

      // quotient estimate by reciprocal, may be one short
      assign eprod_in = 62'(ma_x_ff[n]) * 62'(lmu_pkg::RECIP_Q30[n]);

      always_ff @(posedge clock) begin
         mb_valid_ff[n] <= ma_valid_ff[n] & ~reset;
         mb_p_ff[n]     <= ma_p_ff[n];
         mb_k_ff[n]     <= ma_k_ff[n];
         mb_y_ff[n]     <= ma_y_ff[n];
         mb_x_ff[n]     <= ma_x_ff[n];
         mb_est_ff[n]   <= eprod_in[60:30];
         mb_sum_ff[n]   <= ma_sum_ff[n];
      end

      // correct the estimate, accumulate
      always_comb begin
         chk_in  = 35'(mb_est_ff[n]) * 35'(n);
         rem_in  = 35'(mb_x_ff[n]) - chk_in;
         term_in = (rem_in >= 35'(n)) ? mb_est_ff[n] + SW'(1) : mb_est_ff[n];
      end

      always_ff @(posedge clock) begin
         ser_valid_ff[n] <= mb_valid_ff[n] & ~reset;
         ser_p_ff[n]     <= mb_p_ff[n];
         ser_k_ff[n]     <= mb_k_ff[n];
         ser_y_ff[n]     <= mb_y_ff[n];
         ser_term_ff[n]  <= term_in;
         ser_sum_ff[n]   <= mb_sum_ff[n] + term_in;
      end
   end

   // Product stage: p * 2^f, and the weight of 1 - p
   logic                  pr_valid_ff;
   logic [A_W-1:0]        pr_a_ff;
   logic [PW-1:0]         pr_bb_ff;
   logic signed [K_W-1:0] pr_k_ff;

   always_ff @(posedge clock) begin
      pr_valid_ff <= ser_valid_ff[TERMS] & ~reset;
      pr_a_ff     <= A_W'(ser_p_ff[TERMS]) * A_W'(ser_sum_ff[TERMS]);
      pr_bb_ff    <= lmu_pkg::ONE_VAL - ser_p_ff[TERMS];
      pr_k_ff     <= ser_k_ff[TERMS];
   end

   // Divider pipeline; index 0 is the shift stage output
   logic            dv_valid_ff [0:Q_W];
   logic [ND_W-1:0] dv_r_ff     [0:Q_W];
   logic [ND_W-1:0] dv_den_ff   [0:Q_W];
   logic [Q_W-1:0]  dv_q_ff     [0:Q_W];
   logic            dv_zero_ff  [0:Q_W];

   // Shift stage: scale p*2^f by 2^k when k is negative, else 1 - p by 2^-k
   logic [ND_W-1:0] a_full_in, b_full_in, num_in, den_in, sh_in;
   logic [K_W-1:0]  mag_in;
   logic            neg_in;

   always_comb begin
      a_full_in = ND_W'(pr_a_ff) << lmu_pkg::M_SHIFT;
      b_full_in = ND_W'(pr_bb_ff) << lmu_pkg::DIV_BITS;
      neg_in    = pr_k_ff[K_W-1];
      mag_in    = neg_in ? K_W'(-pr_k_ff) : K_W'(pr_k_ff);
      sh_in     = neg_in ? a_full_in : b_full_in;
      if (|mag_in[K_W-1:6]) sh_in = '0;
      else                  sh_in = sh_in >> mag_in[5:0];
      if (neg_in) begin
         num_in = sh_in;
         den_in = sh_in + b_full_in;
      end else begin
         num_in = a_full_in;
         den_in = a_full_in + sh_in;
      end
   end

   always_ff @(posedge clock) begin
      dv_valid_ff[0] <= pr_valid_ff & ~reset;
      dv_r_ff[0]     <= num_in;
      dv_den_ff[0]   <= den_in;
      dv_q_ff[0]     <= '0;
      dv_zero_ff[0]  <= (den_in == '0);
   end

   // Restoring division, one quotient bit per stage
   for (genvar j = 1; j <= Q_W; j++) begin : g_div
      logic [ND_W:0]   rr_in;
      logic            bit_in;
      logic [ND_W:0]   diff_in;

      always_comb begin
         rr_in   = (j == 1) ? {1'b0, dv_r_ff[j-1]} : {dv_r_ff[j-1], 1'b0};
         bit_in  = (rr_in >= {1'b0, dv_den_ff[j-1]});
         diff_in = rr_in - {1'b0, dv_den_ff[j-1]};
      end

      always_ff @(posedge clock) begin
         dv_valid_ff[j] <= dv_valid_ff[j-1] & ~reset;
         dv_r_ff[j]     <= bit_in ? diff_in[ND_W-1:0] : rr_in[ND_W-1:0];
         dv_den_ff[j]   <= dv_den_ff[j-1];
         dv_q_ff[j]     <= {dv_q_ff[j-1][Q_W-2:0], bit_in};
         dv_zero_ff[j]  <= dv_zero_ff[j-1];
      end
   end

   // Round, final clamp, output register
   logic [Q_W:0]   qr_in;
   logic [Q_W-1:0] v_in, c_in;
   logic           rsp_valid_ff, rsp_hit_ff;
   logic [15:0]    rsp_value_ff;

   always_comb begin
      qr_in = {1'b0, dv_q_ff[Q_W]} + (Q_W+1)'(1);
      v_in  = dv_zero_ff[Q_W] ? Q_W'(lmu_pkg::ONE_VAL) : qr_in[Q_W:1];
      c_in  = v_in;
      if (c_in > Q_W'(ceiling_level_ff)) c_in = Q_W'(ceiling_level_ff);
      if (c_in < Q_W'(floor_level_ff))   c_in = Q_W'(floor_level_ff);
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= dv_valid_ff[Q_W] & ~reset;
      rsp_value_ff <= c_in[15:0];
      rsp_hit_ff   <= (c_in != v_in);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_updated_value = rsp_value_ff;
   assign rsp_hit_bound     = rsp_hit_ff;

`ifndef SYNTHESIS
   // a flagged result sits on one of the bounds
   a_hit_on_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_bound |->
         (rsp_updated_value == floor_level_ff) || (rsp_updated_value == ceiling_level_ff))
      else $error("flagged result not on a bound");

   // with ordered bounds the result lies between them
   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (floor_level_ff <= ceiling_level_ff) |->
         (rsp_updated_value >= floor_level_ff) && (rsp_updated_value <= ceiling_level_ff))
      else $error("result outside bounds");

   // 2^f is never below one
   a_series_sum: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff[TERMS] |-> ser_sum_ff[TERMS] >= lmu_pkg::ONE_Q30)
      else $error("series sum below one");
`endif

endmodule
`default_nettype wire
